### src/dvrt_pkg.sv
// Shared types and codes for the distance-vector route table.
`default_nettype none
package dvrt_pkg;

    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [47:0] dmac;
        logic [47:0] nh;
        logic [7:0]  hops;
        logic [31:0] stamp;
    } ent_t;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_ADVERT = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_EXPIRE = 3'd4;
    localparam logic [2:0] OP_CLRCHG = 3'd5;

    localparam logic [3:0] ST_NEW      = 4'd0;
    localparam logic [3:0] ST_UPDATED  = 4'd1;
    localparam logic [3:0] ST_KEPT     = 4'd2;
    localparam logic [3:0] ST_EVICTED  = 4'd3;
    localparam logic [3:0] ST_FULL     = 4'd4;
    localparam logic [3:0] ST_SELF     = 4'd5;
    localparam logic [3:0] ST_WITHDRAW = 4'd6;
    localparam logic [3:0] ST_POISON   = 4'd7;
    localparam logic [3:0] ST_FOUND    = 4'd8;
    localparam logic [3:0] ST_NOTFOUND = 4'd9;
    localparam logic [3:0] ST_REMOVED  = 4'd10;
    localparam logic [3:0] ST_DONE     = 4'd11;

    localparam logic [7:0] POISON_HOPS = 8'd16;
    localparam logic [7:0] DIRECT_HOPS = 8'd1;

endpackage
`default_nettype wire

### src/distance_vector_route_table_core.sv
// Distance-vector route table: a ring of entry cells scanned by one controller.
//
// Input channel s_*: one operation per item (add, advert entry, lookup,
// remove, expire tick, clear change flag). Result channel m_*: exactly one
// result item per input item. Configuration channel cfg_*: index 0 writes
// the local MAC, index 1 the route expiry age in ms; always ready.
// Entries sit in a ring of TABLE_DEPTH cells that rotates one place per
// cycle during a scan or write pass. A full rotation scans every entry at
// the ring tail (match, lowest free slot, eviction score, expiry); a second
// rotation writes or removes the chosen entry as it passes the tail.
// Lookup, expire and rejected operations skip the second rotation.
// One item is in work at a time; the next is accepted once the result is in
// the output register, even if the receiver has not taken it yet. A stalled
// receiver holds the result and the block waits after its next scan.
// Reset clears every valid bit, the route count, the change flag and the
// advert counter at once; the block is ready in the cycle after reset.
`default_nettype none
module distance_vector_route_table_core
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [31:0] s_dest_ip,
    input  wire logic [47:0] s_dest_mac,
    input  wire logic [47:0] s_next_hop_mac,
    input  wire logic [7:0]  s_hop_count,
    input  wire logic [31:0] s_now_ms,
    input  wire logic        s_last_entry,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_status,
    output logic [4:0]       m_slot,
    output logic [7:0]       m_found_hop_count,
    output logic [47:0]      m_found_next_hop,
    output logic [47:0]      m_found_dest_mac,
    output logic [5:0]       m_route_count,
    output logic             m_topology_changed,
    output logic [7:0]       m_adv_installed,
    output logic [5:0]       m_expired_count,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {IDLE, SCAN, DECIDE, APPLY, EMIT} state_t;
    typedef enum logic [1:0] {WR_NONE, WR_UPD, WR_NEW, WR_DEL} wr_t;

    typedef struct packed {
        wr_t           kind;
        logic [IW-1:0] tgt;
        logic [3:0]    status;
        logic          has_slot;
        logic [7:0]    hops;
        logic [47:0]   nh;
        logic [47:0]   dmac;
        logic [CW-1:0] count;
        logic          changed;
        logic [7:0]    adv_out;
        logic [7:0]    adv_next;
    } dec_t;

    state_t        state_reg;
    logic [IW-1:0] idx_reg;

    logic [47:0] local_mac_reg;
    logic [31:0] expire_ms_reg;
    logic [CW-1:0] count_reg;
    logic          change_reg;
    logic [7:0]    adv_reg;

    logic [2:0]  op_reg;
    logic [31:0] ip_reg;
    logic [47:0] dmac_reg;
    logic [47:0] nh_reg;
    logic [7:0]  hops_reg;
    logic [31:0] now_reg;
    logic        last_reg;

    logic          fnd_reg;
    logic [IW-1:0] fidx_reg;
    logic [7:0]    fhops_reg;
    logic [47:0]   fnh_reg;
    logic [47:0]   fdmac_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;
    logic          worst_f_reg;
    logic [31:0]   worst_reg;
    logic [IW-1:0] worst_idx_reg;
    logic [CW-1:0] exp_reg;

    dec_t dec;
    wr_t           kind_reg;
    logic [IW-1:0] tgt_reg;
    logic [3:0]    r_status_reg;
    logic [IW-1:0] r_slot_reg;
    logic [7:0]    r_hops_reg;
    logic [47:0]   r_nh_reg;
    logic [47:0]   r_dmac_reg;
    logic [7:0]    r_adv_reg;

    logic             m_valid_reg;
    logic [3:0]       m_status_reg;
    logic [4:0]       m_slot_reg;
    logic [7:0]       m_hops_reg;
    logic [47:0]      m_nh_reg;
    logic [47:0]      m_dmac_reg;
    logic [5:0]       m_count_reg;
    logic             m_change_reg;
    logic [7:0]       m_adv_reg;
    logic [5:0]       m_exp_reg;

    ent_t cell_in  [TABLE_DEPTH];
    ent_t cell_out [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_vec;
    ent_t tail;
    ent_t fb;
    logic shift_en;
    logic [31:0] tail_age;
    logic [31:0] tail_score;
    logic        tail_match;

    assign shift_en = (state_reg == SCAN) || (state_reg == APPLY);
    assign tail     = cell_out[TABLE_DEPTH-1];
    assign tail_age = now_reg - tail.stamp;
    assign tail_score = {tail.hops, tail_age[31:8]};
    assign tail_match = tail.valid && (tail.ip == ip_reg);

    // Ring of cells: tail feeds back to the head through the edit logic.
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_ring
            if (g == 0) begin : g_head
                assign cell_in[g] = fb;
            end else begin : g_link
                assign cell_in[g] = cell_out[g-1];
            end
            dvrt_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift_en(shift_en),
                .ent_in  (cell_in[g]),
                .ent_out (cell_out[g])
            );
            assign valid_vec[g] = cell_out[g].valid;
        end
    endgenerate

    always_comb begin
        fb = tail;
        if (state_reg == SCAN && op_reg == OP_EXPIRE && tail.valid &&
            tail_age > expire_ms_reg) begin
            fb.valid = 1'b0;
        end
        if (state_reg == APPLY && idx_reg == tgt_reg) begin
            case (kind_reg)
                WR_UPD: begin
                    fb.nh    = nh_reg;
                    fb.hops  = hops_reg;
                    fb.stamp = now_reg;
                end
                WR_NEW: begin
                    fb.valid = 1'b1;
                    fb.ip    = ip_reg;
                    fb.dmac  = dmac_reg;
                    fb.nh    = nh_reg;
                    fb.hops  = hops_reg;
                    fb.stamp = now_reg;
                end
                WR_DEL: begin
                    fb.valid = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Decide the operation from the scan summary.
    always_comb begin
        logic do_add;
        dec          = '0;
        dec.kind     = WR_NONE;
        dec.status   = ST_DONE;
        dec.count    = count_reg;
        dec.changed  = change_reg;
        dec.adv_out  = adv_reg;
        dec.adv_next = adv_reg;
        do_add       = 1'b0;
        case (op_reg)
            OP_ADD, OP_ADVERT: begin
                if (op_reg == OP_ADVERT && dmac_reg == local_mac_reg) begin
                    dec.status = ST_SELF;
                end else if (op_reg == OP_ADVERT && hops_reg >= POISON_HOPS) begin
                    if (fnd_reg && fnh_reg == nh_reg) begin
                        dec.kind     = WR_DEL;
                        dec.tgt      = fidx_reg;
                        dec.status   = ST_WITHDRAW;
                        dec.has_slot = 1'b1;
                        dec.hops     = fhops_reg;
                        dec.nh       = fnh_reg;
                        dec.dmac     = fdmac_reg;
                        dec.count    = count_reg - CW'(1);
                        dec.changed  = 1'b1;
                    end else begin
                        dec.status = ST_POISON;
                    end
                end else begin
                    do_add = 1'b1;
                end
                if (do_add) begin
                    if (fnd_reg) begin
                        dec.tgt      = fidx_reg;
                        dec.has_slot = 1'b1;
                        dec.hops     = fhops_reg;
                        dec.nh       = fnh_reg;
                        dec.dmac     = fdmac_reg;
                        dec.status   = ST_KEPT;
                        if (!(fhops_reg == DIRECT_HOPS && fnh_reg != nh_reg) &&
                            (hops_reg < fhops_reg || fnh_reg == nh_reg)) begin
                            dec.kind    = WR_UPD;
                            dec.status  = ST_UPDATED;
                            dec.hops    = hops_reg;
                            dec.nh      = nh_reg;
                            dec.changed = 1'b1;
                        end
                    end else if (free_reg || worst_f_reg) begin
                        dec.kind     = WR_NEW;
                        dec.tgt      = free_reg ? free_idx_reg : worst_idx_reg;
                        dec.status   = free_reg ? ST_NEW : ST_EVICTED;
                        dec.has_slot = 1'b1;
                        dec.hops     = hops_reg;
                        dec.nh       = nh_reg;
                        dec.dmac     = dmac_reg;
                        dec.changed  = 1'b1;
                        if (free_reg) begin
                            dec.count = count_reg + CW'(1);
                        end
                    end else begin
                        dec.status = ST_FULL;
                    end
                end
                if (op_reg == OP_ADVERT) begin
                    if (do_add && adv_reg != 8'hFF) begin
                        dec.adv_out = adv_reg + 8'd1;
                    end
                    dec.adv_next = last_reg ? 8'd0 : dec.adv_out;
                end
            end
            OP_LOOKUP: begin
                dec.status   = fnd_reg ? ST_FOUND : ST_NOTFOUND;
                dec.tgt      = fidx_reg;
                dec.has_slot = fnd_reg;
                dec.hops     = fhops_reg;
                dec.nh       = fnh_reg;
                dec.dmac     = fdmac_reg;
            end
            OP_REMOVE: begin
                dec.status = ST_NOTFOUND;
                if (fnd_reg) begin
                    dec.kind     = WR_DEL;
                    dec.tgt      = fidx_reg;
                    dec.status   = ST_REMOVED;
                    dec.has_slot = 1'b1;
                    dec.hops     = fhops_reg;
                    dec.nh       = fnh_reg;
                    dec.dmac     = fdmac_reg;
                    dec.count    = count_reg - CW'(1);
                    dec.changed  = 1'b1;
                end
            end
            OP_EXPIRE: begin
                dec.count = count_reg - exp_reg;
                if (exp_reg != '0) begin
                    dec.changed = 1'b1;
                end
            end
            OP_CLRCHG: begin
                dec.changed = 1'b0;
            end
            default: begin
            end
        endcase
        if (!dec.has_slot) begin
            dec.tgt  = '0;
            dec.hops = '0;
            dec.nh   = '0;
            dec.dmac = '0;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_mac_reg <= '0;
            expire_ms_reg <= 32'd30000;
        end else if (cfg_valid) begin
            if (cfg_index == 8'd0) begin
                local_mac_reg <= cfg_data;
            end else if (cfg_index == 8'd1) begin
                expire_ms_reg <= cfg_data[31:0];
            end
        end
    end

    logic [IW+4:0] slot_wide;
    logic [CW+5:0] count_wide;
    logic [CW+5:0] exp_wide;
    assign slot_wide  = {5'b0, r_slot_reg};
    assign count_wide = {6'b0, count_reg};
    assign exp_wide   = {6'b0, exp_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            idx_reg     <= LAST_IDX;
            count_reg   <= '0;
            change_reg  <= 1'b0;
            adv_reg     <= '0;
            m_valid_reg <= 1'b0;
            kind_reg    <= WR_NONE;
        end else begin
            // Drop the taken result unless a new one is loaded below.
            if (m_valid_reg && m_ready && state_reg != EMIT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        op_reg      <= s_op;
                        ip_reg      <= s_dest_ip;
                        dmac_reg    <= s_dest_mac;
                        nh_reg      <= s_next_hop_mac;
                        hops_reg    <= s_hop_count;
                        now_reg     <= s_now_ms;
                        last_reg    <= s_last_entry;
                        fnd_reg     <= 1'b0;
                        free_reg    <= 1'b0;
                        worst_f_reg <= 1'b0;
                        worst_reg   <= '0;
                        exp_reg     <= '0;
                        idx_reg     <= LAST_IDX;
                        state_reg   <= SCAN;
                    end
                end
                SCAN: begin
                    // Tail walks from the highest index down; later hits win.
                    if (tail_match) begin
                        fnd_reg   <= 1'b1;
                        fidx_reg  <= idx_reg;
                        fhops_reg <= tail.hops;
                        fnh_reg   <= tail.nh;
                        fdmac_reg <= tail.dmac;
                    end
                    if (!tail.valid) begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= idx_reg;
                    end else if (tail_score != '0 && tail_score >= worst_reg) begin
                        worst_f_reg   <= 1'b1;
                        worst_reg     <= tail_score;
                        worst_idx_reg <= idx_reg;
                    end
                    if (op_reg == OP_EXPIRE && tail.valid &&
                        tail_age > expire_ms_reg) begin
                        exp_reg <= exp_reg + CW'(1);
                    end
                    idx_reg <= idx_reg - IW'(1);
                    if (idx_reg == '0) begin
                        idx_reg   <= LAST_IDX;
                        state_reg <= DECIDE;
                    end
                end
                DECIDE: begin
                    kind_reg     <= dec.kind;
                    tgt_reg      <= dec.tgt;
                    r_status_reg <= dec.status;
                    r_slot_reg   <= dec.tgt;
                    r_hops_reg   <= dec.hops;
                    r_nh_reg     <= dec.nh;
                    r_dmac_reg   <= dec.dmac;
                    r_adv_reg    <= dec.adv_out;
                    count_reg    <= dec.count;
                    change_reg   <= dec.changed;
                    adv_reg      <= dec.adv_next;
                    idx_reg      <= LAST_IDX;
                    state_reg    <= (dec.kind == WR_NONE) ? EMIT : APPLY;
                end
                APPLY: begin
                    idx_reg <= idx_reg - IW'(1);
                    if (idx_reg == '0) begin
                        idx_reg   <= LAST_IDX;
                        state_reg <= EMIT;
                    end
                end
                EMIT: begin
                    // Hold here while the previous result is still unread.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= r_status_reg;
                        m_slot_reg   <= slot_wide[4:0];
                        m_hops_reg   <= r_hops_reg;
                        m_nh_reg     <= r_nh_reg;
                        m_dmac_reg   <= r_dmac_reg;
                        m_count_reg  <= count_wide[5:0];
                        m_change_reg <= change_reg;
                        m_adv_reg    <= r_adv_reg;
                        m_exp_reg    <= (op_reg == OP_EXPIRE) ? exp_wide[5:0] : 6'd0;
                        kind_reg     <= WR_NONE;
                        state_reg    <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign s_ready            = (state_reg == IDLE);
    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_slot             = m_slot_reg;
    assign m_found_hop_count  = m_hops_reg;
    assign m_found_next_hop   = m_nh_reg;
    assign m_found_dest_mac   = m_dmac_reg;
    assign m_route_count      = m_count_reg;
    assign m_topology_changed = m_change_reg;
    assign m_adv_installed    = m_adv_reg;
    assign m_expired_count    = m_exp_reg;

    a_count_matches_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == IDLE) |-> ($countones(valid_vec) == int'(count_reg)))
        else $error("route count disagrees with valid entries");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= TABLE_DEPTH)
        else $error("route count above table depth");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == EMIT))
        else $error("result raised outside emit");

    a_ring_still_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == IDLE) |=> $stable(valid_vec) || $past(s_valid))
        else $error("ring moved while idle");

endmodule
`default_nettype wire

### src/dvrt_cell.sv
// One route table entry; hands its entry to the next cell on each shift.
`default_nettype none
module dvrt_cell
    import dvrt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic shift_en,
    input  wire ent_t ent_in,
    output ent_t      ent_out
);

    logic valid_reg;
    ent_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= ent_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= ent_in;
        end
    end

    always_comb begin
        ent_out       = data_reg;
        ent_out.valid = valid_reg;
    end

endmodule
`default_nettype wire
